/* rtl/indexed_double_ended_queue_assert.svh */
// Assertion macros for the deque RTL, included by deq_ctrl.
// Every macro expects signals named clk and rst_n in the including scope.
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define DEQ_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define DEQ_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define DEQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// Shared types and constants for the indexed double-ended queue.
// Used by deq_ctrl, indexed_double_ended_queue and the testbench; no dependencies.
`default_nettype none

package deq_pkg;

    // Field widths of the stream words.
    localparam int FUNC_W     = 3;
    localparam int ITEM_W     = 32;
    localparam int POS_W      = 10;
    localparam int RVAL_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 11;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FIRST = 3'd4,
        FN_PEEK_LAST  = 3'd5,
        FN_READ_AT    = 3'd6,
        FN_WRITE_AT   = 3'd7
    } func_t;

    // Status codes returned with every result word.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Outcome of one executed operation, handed to the result register.
    typedef struct packed {
        status_t status;
        logic    rd_ok;
        logic    is_push;
    } exec_res_t;

endpackage

`default_nettype wire

/* rtl/indexed_double_ended_queue.sv */
// Indexed double-ended queue on a single circular store, top level.
// Depends on deq_pkg, deq_ctrl and deq_ring_mem.
//
//   Channel   Dir  Contents of tdata, low bit first
//   s_axis    in   func, item_value, position (request word)
//   m_axis    out  read_value, status, occupancy (result word)
//
// One request word per cycle is accepted while the result side is not stalled;
// each gives one result word after the input register, the execute stage with
// store access, and the result register fed by the registered store read port.
// The store has no reset and is not cleared; pointer and count reset to zero.
// A stalled result freezes the execute stage; the input register still
// takes one word while the result waits.
`default_nettype none

module indexed_double_ended_queue #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [2:0] func, [34:3] item_value, [44:35] position, [47:45] zero
    input  wire logic [deq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [31:0] read_value, [33:32] status, [44:34] occupancy, [47:45] zero
    output logic      [deq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (DATA_WIDTH < deq_pkg::ITEM_W) ? DATA_WIDTH : deq_pkg::ITEM_W;
    localparam int XW = (CW > deq_pkg::OCC_W) ? CW : deq_pkg::OCC_W;

    logic                          in_valid_reg;
    logic [deq_pkg::FUNC_W-1:0]    func_reg;
    logic [deq_pkg::ITEM_W-1:0]    item_reg;
    logic [deq_pkg::POS_W-1:0]     pos_reg;

    logic                          out_valid_reg;
    deq_pkg::status_t              status_reg;
    logic                          rd_ok_reg;
    logic [deq_pkg::OCC_W-1:0]     occ_reg;

    logic                          advance;
    logic                          exec_en;
    logic                          mem_we;
    logic                          mem_re;
    logic [PW-1:0]                 mem_addr;
    logic [SW-1:0]                 mem_wdata;
    logic [SW-1:0]                 mem_rdata;
    deq_pkg::exec_res_t            res;
    logic [CW-1:0]                 count;
    logic [XW-1:0]                 count_ext;
    logic [deq_pkg::RVAL_W-1:0]    read_value;

    // Pipeline moves when the result register is free or being taken.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign exec_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register: valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register: request word.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            func_reg <= s_axis_tdata[2:0];
            item_reg <= s_axis_tdata[34:3];
            pos_reg  <= s_axis_tdata[44:35];
        end
    end

    deq_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (exec_en),
        .func       (func_reg),
        .item_value (item_reg),
        .position   (pos_reg),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .res        (res),
        .count      (count)
    );

    deq_ring_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign count_ext = XW'(count);

    // Result register: valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register: status, occupancy and read flag; data comes from the store.
    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            status_reg <= res.status;
            rd_ok_reg  <= res.rd_ok;
            occ_reg    <= count_ext[deq_pkg::OCC_W-1:0];
        end
    end

    // Data is zero unless the operation read a word.
    assign read_value = rd_ok_reg ? deq_pkg::RVAL_W'(mem_rdata) : '0;

    // Result word.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, occ_reg, status_reg, read_value};

endmodule

`default_nettype wire

/* rtl/deq_ring_mem.sv */
// Circular data store of the deque: one port, synchronous write, registered read.
// Standalone; instantiated by indexed_double_ended_queue.
`default_nettype none

module deq_ring_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port; holds its word while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/deq_ctrl.sv */
// Execute stage of the deque: front pointer, entry count and store addressing.
// Depends on deq_pkg and on indexed_double_ended_queue_assert.svh.
`default_nettype none

`include "indexed_double_ended_queue_assert.svh"

module deq_ctrl #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic [deq_pkg::FUNC_W-1:0]    func,
    input  wire logic [deq_pkg::ITEM_W-1:0]    item_value,
    input  wire logic [deq_pkg::POS_W-1:0]     position,
    output logic                               mem_we,
    output logic                               mem_re,
    output logic      [$clog2(DEPTH)-1:0]      mem_addr,
    output logic      [WIDTH-1:0]              mem_wdata,
    output deq_pkg::exec_res_t                 res,
    output logic      [$clog2(DEPTH+1)-1:0]    count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;

    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    logic [PW-1:0] front_inc, front_dec;
    logic [PW-1:0] offset;
    logic [PW:0]   slot_sum;
    logic [PW-1:0] slot;
    logic [OW-1:0] pos_ext;
    logic [OW-1:0] count_ext;
    logic [CW-1:0] count_dec;
    logic          is_full;
    logic          is_empty;
    logic          do_write;
    logic          do_read;
    logic          use_front;
    logic          use_dec;
    deq_pkg::func_t   fn;
    deq_pkg::status_t status;

    assign fn        = deq_pkg::func_t'(func);
    assign pos_ext   = OW'(position);
    assign count_ext = OW'(count_reg);
    assign count_dec = count_reg - CW'(1);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    // Neighbors of the front slot on the ring.
    assign front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + PW'(1);
    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - PW'(1);

    // Slot at an offset from the front; both terms are below DEPTH.
    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= (PW + 1)'(DEPTH)) ? PW'(slot_sum - (PW + 1)'(DEPTH))
                                                     : slot_sum[PW-1:0];

    // Operation decode.
    always_comb
    begin
        status     = deq_pkg::ST_OK;
        offset     = '0;
        do_write   = 1'b0;
        do_read    = 1'b0;
        use_front  = 1'b0;
        use_dec    = 1'b0;
        front_next = front_reg;
        count_next = count_reg;
        unique case (fn) inside
            deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK:
            begin
                offset = count_reg[PW-1:0];
                if (is_full)
                begin
                    status = deq_pkg::ST_FULL;
                end
                else
                begin
                    do_write   = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (fn == deq_pkg::FN_PUSH_FRONT)
                    begin
                        use_dec    = 1'b1;
                        front_next = front_dec;
                    end
                end
            end
            deq_pkg::FN_POP_FRONT, deq_pkg::FN_PEEK_FIRST:
            begin
                if (is_empty)
                begin
                    status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    do_read   = 1'b1;
                    use_front = 1'b1;
                    if (fn == deq_pkg::FN_POP_FRONT)
                    begin
                        front_next = front_inc;
                        count_next = count_dec;
                    end
                end
            end
            deq_pkg::FN_POP_BACK, deq_pkg::FN_PEEK_LAST:
            begin
                offset = count_dec[PW-1:0];
                if (is_empty)
                begin
                    status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    do_read = 1'b1;
                    if (fn == deq_pkg::FN_POP_BACK)
                    begin
                        count_next = count_dec;
                    end
                end
            end
            default:
            begin
                // Read at or write at a position counted from the front.
                offset = pos_ext[PW-1:0];
                if (pos_ext >= count_ext)
                begin
                    status = deq_pkg::ST_RANGE;
                end
                else if (fn == deq_pkg::FN_READ_AT)
                begin
                    do_read = 1'b1;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
        endcase
    end

    // Store request and result of this operation.
    assign mem_addr    = use_front ? front_reg : (use_dec ? front_dec : slot);
    assign mem_we      = en && do_write;
    assign mem_re      = en && do_read;
    assign mem_wdata   = WIDTH'(item_value);
    assign res.status  = status;
    assign res.rd_ok   = do_read;
    assign res.is_push = (fn == deq_pkg::FN_PUSH_FRONT) || (fn == deq_pkg::FN_PUSH_BACK);
    assign count       = count_next;

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    `DEQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "entry count above depth")
    `DEQ_ASSERT_SAME(a_full_only_at_depth, en && (res.status == deq_pkg::ST_FULL), count_reg == CW'(DEPTH), "full reported below depth")
    `DEQ_ASSERT_NEXT(a_push_grows, en && (res.status == deq_pkg::ST_OK) && res.is_push, count_reg == $past(count_reg) + CW'(1), "push did not add one entry")
    `DEQ_ASSERT_NEXT(a_idle_holds, !en, $stable(count_reg) && $stable(front_reg), "state moved without an operation")

endmodule

`default_nettype wire

/* tb/deq_checker.sv */
// Checker for the indexed double-ended queue: watches both stream channels,
// predicts every result word from the accepted requests and compares them.
// Depends on deq_pkg for field widths, operation and status codes.
module deq_checker
    import deq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    // [2:0] func, [34:3] item_value, [44:35] position, [47:45] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] read_value, [33:32] status, [44:34] occupancy, [47:45] zero
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                          fail_count,
    output int                          outstanding,
    output logic      [OCC_W-1:0]       held_count
);

    localparam int RING_DEPTH = 1024;

    typedef struct packed {
        logic [RVAL_W-1:0] value;
        status_t           status;
        logic [OCC_W-1:0]  occ;
    } deq_result_t;

    // Shadow copy of the queue contents, front index and entry count.
    logic [ITEM_W-1:0] shadow_store [RING_DEPTH];
    logic [POS_W-1:0]  shadow_front;
    logic [OCC_W-1:0]  shadow_count;

    // Predicted result words, oldest first.
    deq_result_t pending_results [$];

    assign held_count = shadow_count;

    // Executes one request word on the shadow queue and returns its result.
    function automatic deq_result_t apply_request(input logic [IN_TDATA_W-1:0] req);
        func_t            op;
        logic [ITEM_W-1:0] item;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  slot;
        deq_result_t       res;
        op         = func_t'(req[FUNC_W-1:0]);
        item       = req[FUNC_W +: ITEM_W];
        pos        = req[FUNC_W + ITEM_W +: POS_W];
        res.value  = '0;
        res.status = ST_OK;
        case (op)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (shadow_count == OCC_W'(RING_DEPTH))
                begin
                    res.status = ST_FULL;
                end
                else if (op == FN_PUSH_FRONT)
                begin
                    shadow_front = shadow_front - 1'b1;
                    shadow_store[shadow_front] = item;
                    shadow_count = shadow_count + 1'b1;
                end
                else
                begin
                    slot = shadow_front + shadow_count[POS_W-1:0];
                    shadow_store[slot] = item;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FIRST, FN_PEEK_LAST:
            begin
                if (shadow_count == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else if (op == FN_POP_FRONT || op == FN_PEEK_FIRST)
                begin
                    res.value = shadow_store[shadow_front];
                    if (op == FN_POP_FRONT)
                    begin
                        shadow_front = shadow_front + 1'b1;
                        shadow_count = shadow_count - 1'b1;
                    end
                end
                else
                begin
                    // A full ring wraps the last entry to just behind the front.
                    slot = shadow_front + shadow_count[POS_W-1:0] - 1'b1;
                    res.value = shadow_store[slot];
                    if (op == FN_POP_BACK)
                    begin
                        shadow_count = shadow_count - 1'b1;
                    end
                end
            end
            default:
            begin
                slot = shadow_front + pos;
                if (OCC_W'(pos) >= shadow_count)
                begin
                    res.status = ST_RANGE;
                end
                else if (op == FN_READ_AT)
                begin
                    res.value = shadow_store[slot];
                end
                else
                begin
                    shadow_store[slot] = item;
                end
            end
        endcase
        res.occ = shadow_count;
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result words are checked before the request of the same edge is predicted;
    // the pipeline never returns a word in the cycle its request is taken.
    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t want;
        if (!rst_n)
        begin
            shadow_front = '0;
            shadow_count = '0;
            pending_results.delete();
            fail_count   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result word 0x%0h", $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("read_value", want.value, m_axis_tdata[31:0]);
                    compare_field("status", 32'(want.status), 32'(m_axis_tdata[33:32]));
                    compare_field("occupancy", 32'(want.occ), 32'(m_axis_tdata[44:34]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_results.push_back(apply_request(s_axis_tdata));
            end
            outstanding = pending_results.size();
        end
    end

endmodule

/* tb/testbench.sv */
// Top of the deque regression: clock, reset, request stimulus, result-side
// stalls and the final verdict. Depends on deq_pkg, deq_checker and the
// indexed_double_ended_queue RTL.
module testbench;
    import deq_pkg::*;

    localparam int RING_DEPTH  = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int               fail_count;
    int               outstanding;
    logic [OCC_W-1:0] held_count;
    int               idle_cycles = 0;

    // Shared idling controls: calm turns off gaps on both sides,
    // hold_req asks the result side for one long hold-off.
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    always #10 clk = ~clk;

    indexed_double_ended_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    deq_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .held_count    (held_count)
    );

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
        begin
            return 0;
        end
        else if (r < 97)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 40);
    endfunction

    // Offers one request word and returns on the falling edge after it is taken.
    task automatic send_word(input func_t op, input logic [ITEM_W-1:0] item,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, pos, item, op};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Random request; positions lean toward valid offsets and the count boundary.
    task automatic send_random(input int push_pct, input int pop_pct);
        func_t             op;
        logic [ITEM_W-1:0] item;
        logic [POS_W-1:0]  pos;
        int                r;
        int                cnt;
        int                near;
        cnt = held_count;
        r   = $urandom_range(0, 99);
        if (r < push_pct)
        begin
            op = func_t'($urandom_range(0, 1));
        end
        else if (r < push_pct + pop_pct)
        begin
            op = func_t'($urandom_range(2, 3));
        end
        else
        begin
            op = func_t'($urandom_range(4, 7));
        end
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            item = '0;
        end
        else if (r < 20)
        begin
            item = '1;
        end
        else
        begin
            item = $urandom();
        end
        r    = $urandom_range(0, 99);
        near = cnt + $urandom_range(0, 2);
        if (r < 75 && cnt > 0)
        begin
            pos = POS_W'($urandom_range(0, cnt - 1));
        end
        else if (r < 90)
        begin
            pos = (near > RING_DEPTH - 1) ? POS_W'(RING_DEPTH - 1) : POS_W'(near);
        end
        else
        begin
            pos = POS_W'($urandom());
        end
        send_word(op, item, pos);
    endtask

    // Result side: random stalls, and one long hold-off when asked.
    initial
    begin
        int r;
        int n;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                n        = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (calm || r < 70)
            begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 4);
            end
            else if (r < 96)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(20, 50);
            end
            repeat (n) @(negedge clk);
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("indexed_double_ended_queue regression: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty queue: every removal, look-up and indexed access is refused.
        send_word(FN_POP_FRONT, $urandom(), 10'd0);
        send_word(FN_POP_BACK, $urandom(), 10'd0);
        send_word(FN_PEEK_FIRST, $urandom(), 10'd0);
        send_word(FN_PEEK_LAST, $urandom(), 10'd0);
        send_word(FN_READ_AT, $urandom(), 10'd0);
        send_word(FN_WRITE_AT, 32'hFFFF_FFFF, 10'd1023);

        // Pushes at both ends; the first front push wraps the front index.
        send_word(FN_PUSH_BACK, 32'hFFFF_FFFF, 10'd1023);
        send_word(FN_PUSH_FRONT, 32'h0000_0000, 10'd0);
        send_word(FN_PUSH_BACK, 32'hA5A5_A5A5, 10'd0);
        send_word(FN_PUSH_FRONT, 32'h5A5A_5A5A, 10'd1023);
        send_word(FN_PEEK_FIRST, $urandom(), 10'd0);
        send_word(FN_PEEK_LAST, $urandom(), 10'd0);

        // Indexed access inside, at and past the count.
        send_word(FN_READ_AT, $urandom(), 10'd0);
        send_word(FN_READ_AT, $urandom(), 10'd3);
        send_word(FN_READ_AT, $urandom(), 10'd4);
        send_word(FN_READ_AT, $urandom(), 10'd1023);
        send_word(FN_WRITE_AT, 32'hFFFF_FFFF, 10'd2);
        send_word(FN_READ_AT, $urandom(), 10'd2);
        send_word(FN_WRITE_AT, 32'h1234_5678, 10'd4);

        // Drain from both ends and pop once more than held.
        send_word(FN_POP_FRONT, $urandom(), 10'd0);
        send_word(FN_POP_BACK, $urandom(), 10'd0);
        send_word(FN_POP_FRONT, $urandom(), 10'd0);
        send_word(FN_POP_BACK, $urandom(), 10'd0);
        send_word(FN_POP_BACK, $urandom(), 10'd0);
        send_word(FN_PUSH_FRONT, 32'h8000_0001, 10'd0);

        // Balanced traffic with a small occupancy.
        repeat (150) send_random(35, 30);

        // Fill to capacity; the result side holds off for a while at the start
        // so the pipeline backs up into the request channel.
        hold_req = 1'b1;
        while (held_count < OCC_W'(RING_DEPTH))
        begin
            calm = (held_count >= 11'd400 && held_count < 11'd600);
            send_random(90, 5);
        end
        calm = 1'b0;

        // Full queue: refused pushes and access to the last position.
        repeat (6) send_random(100, 0);
        send_word(FN_READ_AT, $urandom(), 10'd1023);
        send_word(FN_WRITE_AT, $urandom(), 10'd1023);
        send_word(FN_READ_AT, $urandom(), 10'd1023);
        send_word(FN_PEEK_LAST, $urandom(), 10'd0);

        // Mixed traffic around the full mark.
        repeat (120) send_random(40, 30);

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("indexed_double_ended_queue regression: pass");
        end
        else
        begin
            $display("indexed_double_ended_queue regression: fail");
        end
        $finish;
    end

endmodule
